FILE: rtl/stpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpw_pkg
// Shared types, constants and helpers of the stage-2 page table walker.
// ----------------------------------------------------------------------------
package stpw_pkg;

   localparam int TBL_PAGES  = 16;
   localparam int IDX_W      = 9;
   localparam int DESCS      = 1 << IDX_W;
   localparam int DEPTH      = TBL_PAGES * DESCS;
   localparam int PG_W       = (TBL_PAGES > 1) ? $clog2(TBL_PAGES) : 1;
   localparam int ADDR_W     = PG_W + IDX_W;
   localparam int PU_W       = $clog2(TBL_PAGES + 1);

   localparam logic [1:0] KIND_MAP   = 2'd0;
   localparam logic [1:0] KIND_UNMAP = 2'd1;
   localparam logic [1:0] KIND_XLATE = 2'd2;
   localparam logic [1:0] KIND_UNDEF = 2'd3;

   localparam logic [2:0] REG_POOL_BASE  = 3'd0;
   localparam logic [2:0] REG_IS_RAM     = 3'd1;
   localparam logic [2:0] REG_GUEST_BASE = 3'd2;
   localparam logic [2:0] REG_PA_BASE    = 3'd3;
   localparam logic [2:0] REG_SIZE       = 3'd4;

   localparam logic [1:0] DESC_TABLE = 2'b11;

   typedef enum logic [2:0] {
      ST_OK, ST_INVAL, ST_RANGE, ST_NO_TABLES, ST_MAPPED, ST_UNMAPPED
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHK1, S_CHK2, S_RD, S_EVAL, S_ZERO, S_LINK, S_NEXT, S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [39:0] pool_base;
      logic        region_is_ram;
      logic [39:0] region_guest_base;
      logic [39:0] region_pa_base;
      logic [40:0] region_size;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       chk;
      logic       walk_start;
      logic       rd;
      logic       descend;
      logic       alloc;
      logic       zero_wr;
      logic       link_wr;
      logic       leaf_wr;
      logic       leaf_zero;
      logic       next_page;
      logic       clr_wr;
      logic       set_st;
      status_type st;
      logic       set_pa;
      logic       push;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       inval;
      logic       range_err;
      logic       lvl_last;
      logic       e_table;
      logic       e_valid;
      logic       desc_ok;
      logic       pool_full;
      logic       sweep_last;
      logic       clear_last;
      logic       page_last;
      logic       rsp_free;
   } stat_type;

   // table index of an address at a walk level (0 = root)
   function automatic logic [IDX_W-1:0] level_idx(input logic [39:0] ipa,
                                                  input logic [1:0] lvl);
      logic [IDX_W-1:0] r;
      case (lvl)
         2'd0:    r = ipa[38:30];
         2'd1:    r = ipa[29:21];
         default: r = ipa[20:12];
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/stpw_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpw_csr
// Register bank: pool base and the single guest region.
// ----------------------------------------------------------------------------
module stpw_csr
   import stpw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output cfg_type     cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr;
   logic [2:0] idx;

   assign idx = paddr[5:3];
   assign wr  = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_POOL_BASE:  cfg_in.pool_base         = pwdata[39:0];
            REG_IS_RAM:     cfg_in.region_is_ram     = pwdata[0];
            REG_GUEST_BASE: cfg_in.region_guest_base = pwdata[39:0];
            REG_PA_BASE:    cfg_in.region_pa_base    = pwdata[39:0];
            REG_SIZE:       cfg_in.region_size       = pwdata[40:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else       cfg_ff <= cfg_in;
   end

   always_comb begin
      case (idx)
         REG_POOL_BASE:  prdata = {24'd0, cfg_ff.pool_base};
         REG_IS_RAM:     prdata = {63'd0, cfg_ff.region_is_ram};
         REG_GUEST_BASE: prdata = {24'd0, cfg_ff.region_guest_base};
         REG_PA_BASE:    prdata = {24'd0, cfg_ff.region_pa_base};
         REG_SIZE:       prdata = {23'd0, cfg_ff.region_size};
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/stpw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpw_ctrl
// Sequencer: checks, table walk, allocation sweep and result hand-off.
// ----------------------------------------------------------------------------
module stpw_ctrl
   import stpw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (stat.clear_last) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_CHK1;
         S_CHK1:  state_in = S_CHK2;
         S_CHK2: begin
            if (stat.inval || (stat.kind != KIND_XLATE && stat.range_err)) state_in = S_DONE;
            else state_in = S_RD;
         end
         S_RD:    state_in = S_EVAL;
         S_EVAL: begin
            state_in = S_DONE;
            if (!stat.lvl_last) begin
               if (stat.e_table && stat.desc_ok) state_in = S_RD;
               else if (stat.kind == KIND_MAP && !stat.e_table && !stat.e_valid &&
                        !stat.pool_full) state_in = S_ZERO;
            end else if (stat.kind == KIND_MAP && !stat.e_valid && !stat.page_last) begin
               state_in = S_NEXT;
            end
         end
         S_ZERO:  if (stat.sweep_last) state_in = S_LINK;
         S_LINK:  state_in = S_RD;
         S_NEXT:  state_in = S_RD;
         S_DONE:  if (stat.rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.st = ST_OK;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: cmd.clr_wr = 1'b1;
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_CHK1: cmd.chk = 1'b1;
         S_CHK2: begin
            if (stat.inval) begin
               cmd.set_st = 1'b1;
               cmd.st     = ST_INVAL;
            end else if (stat.kind != KIND_XLATE && stat.range_err) begin
               cmd.set_st = 1'b1;
               cmd.st     = ST_RANGE;
            end else begin
               cmd.walk_start = 1'b1;
            end
         end
         S_RD: cmd.rd = 1'b1;
         S_EVAL: begin
            if (!stat.lvl_last) begin
               if (stat.e_table && stat.desc_ok) begin
                  cmd.descend = 1'b1;
               end else if (stat.kind == KIND_MAP) begin
                  if (!stat.e_table && !stat.e_valid && !stat.pool_full) begin
                     cmd.alloc = 1'b1;
                  end else begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_NO_TABLES;
                  end
               end else begin
                  cmd.set_st = 1'b1;
                  cmd.st     = (stat.kind == KIND_UNMAP) ? ST_OK : ST_UNMAPPED;
               end
            end else begin
               case (stat.kind)
                  KIND_MAP: begin
                     if (stat.e_valid) begin
                        cmd.set_st = 1'b1;
                        cmd.st     = ST_MAPPED;
                     end else begin
                        cmd.leaf_wr = 1'b1;
                        if (stat.page_last) begin
                           cmd.set_st = 1'b1;
                           cmd.st     = ST_OK;
                        end else begin
                           cmd.next_page = 1'b1;
                        end
                     end
                  end
                  KIND_UNMAP: begin
                     cmd.leaf_zero = 1'b1;
                     cmd.set_st    = 1'b1;
                     cmd.st        = ST_OK;
                  end
                  default: begin
                     cmd.set_st = 1'b1;
                     cmd.st     = stat.e_table ? ST_OK : ST_UNMAPPED;
                     cmd.set_pa = stat.e_table;
                  end
               endcase
            end
         end
         S_ZERO:  cmd.zero_wr    = 1'b1;
         S_LINK:  cmd.link_wr    = 1'b1;
         S_NEXT:  cmd.walk_start = 1'b1;
         S_DONE:  cmd.push       = stat.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

FILE: rtl/stpw_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpw_dpath
// Item registers, operand checks, table store and result register.
// ----------------------------------------------------------------------------
module stpw_dpath
   import stpw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  cmd_type      cmd,
   output stat_type     stat,
   input  logic [1:0]   in_kind,
   input  logic [39:0]  in_ipa,
   input  logic [39:0]  in_pa,
   input  logic [40:0]  in_size,
   input  logic [63:0]  in_attrs,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [2:0]   out_status,
   output logic [39:0]  out_pa
);

   logic [63:0] mem [DEPTH];

   logic [1:0]  kind_ff;
   logic [39:0] ipa_ff, pa_ff;
   logic [63:0] attrs_ff;
   logic [28:0] left_ff;

   logic        inval_ff, r1_ff, below_ff, szgt_ff;
   logic [39:0] d_ff;
   logic [40:0] room_ff;

   logic [ADDR_W-1:0] slot_ff, clr_ff;
   logic [1:0]        lvl_ff;
   logic [PG_W-1:0]   pg_ff;
   logic [IDX_W-1:0]  sw_ff;
   logic [PU_W-1:0]   used_ff;
   logic [63:0]       rd_ff;

   status_type  st_ff;
   logic [39:0] pa_out_ff;
   status_type  out_st_ff;
   logic [39:0] out_pa_ff;
   logic        valid_ff;

   // operand checks
   logic [40:0] op_size, sz_m1;
   logic [41:0] last_i, last_p;
   logic [40:0] d_full, room_full;
   logic        inval_c, base_r, pa_bad;
   logic [40:0] pa_exp;

   assign op_size   = (in_kind == KIND_MAP) ? in_size : 41'd4096;
   assign sz_m1     = in_size - 41'd1;
   assign last_i    = {2'd0, in_ipa} + {1'b0, sz_m1};
   assign last_p    = {2'd0, in_pa} + {1'b0, sz_m1};
   assign d_full    = {1'b0, in_ipa} - {1'b0, cfg.region_guest_base};
   assign room_full = cfg.region_size - op_size;

   always_comb begin
      case (in_kind)
         KIND_MAP:   inval_c = (in_ipa[11:0] != '0) || (in_pa[11:0] != '0) ||
                               (in_size[11:0] != '0) || (in_size == '0);
         KIND_UNMAP: inval_c = in_ipa[11:0] != '0;
         KIND_XLATE: inval_c = in_ipa[39:32] != '0;
         default:    inval_c = 1'b1;
      endcase
   end

   assign pa_exp = {1'b0, cfg.region_pa_base} + {1'b0, d_ff};
   assign pa_bad = {1'b0, pa_ff} != pa_exp;
   assign base_r = !cfg.region_is_ram || below_ff || szgt_ff || ({1'b0, d_ff} > room_ff);

   // descriptor decode
   logic [63:0] e;
   logic [40:0] diff;
   logic [27:0] base_pg;
   assign e       = rd_ff;
   assign diff    = {1'b0, e[39:12], 12'd0} - {1'b0, cfg.pool_base};
   assign base_pg = cfg.pool_base[39:12] + 28'(pg_ff);

   always_comb begin
      stat.kind       = kind_ff;
      stat.inval      = inval_ff;
      stat.range_err  = base_r || ((kind_ff == KIND_MAP) && (r1_ff || pa_bad));
      stat.lvl_last   = lvl_ff == 2'd2;
      stat.e_table    = e[1:0] == DESC_TABLE;
      stat.e_valid    = e[0];
      stat.desc_ok    = !diff[40] && (cfg.pool_base[11:0] == '0) &&
                        (diff[39:12] < 28'(TBL_PAGES));
      stat.pool_full  = used_ff >= PU_W'(TBL_PAGES);
      stat.sweep_last = sw_ff == '1;
      stat.clear_last = clr_ff == ADDR_W'(DEPTH - 1);
      stat.page_last  = left_ff == 29'd1;
      stat.rsp_free   = !valid_ff || out_ready;
   end

   // item and check registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= in_kind;
         ipa_ff   <= in_ipa;
         pa_ff    <= in_pa;
         attrs_ff <= in_attrs;
         left_ff  <= in_size[40:12];
         inval_ff <= inval_c;
         r1_ff    <= (last_i[41:32] != '0) || (last_p[41:32] != '0);
         below_ff <= d_full[40];
         szgt_ff  <= room_full[40];
         d_ff     <= d_full[39:0];
         room_ff  <= room_full;
      end
      if (cmd.next_page) begin
         ipa_ff  <= ipa_ff + 40'd4096;
         pa_ff   <= pa_ff + 40'd4096;
         left_ff <= left_ff - 29'd1;
      end
   end

   // walk pointer
   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         lvl_ff  <= 2'd0;
         slot_ff <= {PG_W'(0), level_idx(ipa_ff, 2'd0)};
      end else if (cmd.descend) begin
         lvl_ff  <= lvl_ff + 2'd1;
         slot_ff <= {diff[12 +: PG_W], level_idx(ipa_ff, lvl_ff + 2'd1)};
      end else if (cmd.link_wr) begin
         lvl_ff  <= lvl_ff + 2'd1;
         slot_ff <= {pg_ff, level_idx(ipa_ff, lvl_ff + 2'd1)};
      end
      if (cmd.alloc) begin
         pg_ff <= used_ff[PG_W-1:0];
         sw_ff <= '0;
      end else if (cmd.zero_wr) begin
         sw_ff <= sw_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= PU_W'(1);
         clr_ff  <= '0;
      end else begin
         if (cmd.alloc)  used_ff <= used_ff + PU_W'(1);
         if (cmd.clr_wr) clr_ff  <= clr_ff + ADDR_W'(1);
      end
   end

   // table store, one write and one read port
   logic              we;
   logic [ADDR_W-1:0] wa;
   logic [63:0]       wd;

   always_comb begin
      we = 1'b1;
      wa = slot_ff;
      wd = '0;
      if (cmd.clr_wr)        wa = clr_ff;
      else if (cmd.zero_wr)  wa = {pg_ff, sw_ff};
      else if (cmd.link_wr)  wd = {24'd0, base_pg, 10'd0, DESC_TABLE};
      else if (cmd.leaf_wr)  wd = {attrs_ff[63:40], pa_ff[39:12], attrs_ff[11:2], DESC_TABLE};
      else if (!cmd.leaf_zero) we = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) rd_ff <= mem[slot_ff];
   end

   // working result, built while the item runs
   always_ff @(posedge clock) begin
      if (cmd.load)   pa_out_ff <= '0;
      if (cmd.set_pa) pa_out_ff <= {e[39:12], ipa_ff[11:0]};
      if (cmd.set_st) st_ff <= cmd.st;
   end

   // output register, held until the beat is taken
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_st_ff <= st_ff;
         out_pa_ff <= pa_out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)                valid_ff <= 1'b0;
      else if (cmd.push)        valid_ff <= 1'b1;
      else if (out_ready)       valid_ff <= 1'b0;
   end

   assign out_valid  = valid_ff;
   assign out_status = out_st_ff;
   assign out_pa     = out_pa_ff;

endmodule

FILE: rtl/stage2_page_table_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stage2_page_table_walker
// Three-level stage-2 table pool: map region, unmap page, translate.
// ----------------------------------------------------------------------------
//  channel | dir  | handshake                    | payload
//  req     | in   | req_tvalid / req_tready      | tuser kind, tdata ipa,pa,size,attrs
//  rsp     | out  | rsp_tvalid / rsp_tready      | tuser status, tdata pa_out
//  csr     | in   | APB psel/penable, pready = 1 | five registers at 8-byte steps
//
//  After reset a clearing pass zeroes the table store, one descriptor a cycle:
//  all TBL_PAGES*512 (8192) descriptors, with req_tready low throughout.
//  A full walk runs two checks, three read/decode pairs and the hand-off
//  before the next beat is taken; a failed check goes straight to the
//  hand-off. Each further map page restarts the walk from the root, each new
//  table adds a 512-entry zeroing sweep plus the link write.
//  The result sits in an output register, so the next item is taken while it
//  waits; a stalled rsp only holds the block in its hand-off state.
// ----------------------------------------------------------------------------
module stage2_page_table_walker
   import stpw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [39:0] ipa, [79:40] pa, [120:80] size, [184:121] attrs, rest zero
   input  logic [191:0]  req_tdata,
   // [1:0] kind
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [39:0] pa_out
   output logic [39:0]   rsp_tdata,
   // [2:0] status
   output logic [2:0]    rsp_tuser,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [5:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   assign csr_pready = 1'b1;

   stpw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // sequencer: checks, walk, allocation sweep
   stpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: beat capture, table store, result register
   stpw_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .stat       (stat),
      .in_kind    (req_tuser),
      .in_ipa     (req_tdata[39:0]),
      .in_pa      (req_tdata[79:40]),
      .in_size    (req_tdata[120:80]),
      .in_attrs   (req_tdata[184:121]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (rsp_tuser),
      .out_pa     (rsp_tdata)
   );

   logic unused_pad;
   assign unused_pad = ^req_tdata[191:185];

   // one item in flight: an accepted beat drops ready
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req accepted while item in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= 3'(ST_UNMAPPED)))
      else $error("undefined status code");

   a_pa_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != 3'(ST_OK)) |-> (rsp_tdata == '0))
      else $error("pa_out nonzero on failed item");

endmodule
